FILE: hdl/aldd_pkg.sv
// Shared types and constants of the addressable LED frame driver.
`timescale 1ns / 1ps
`default_nettype none
package aldd_pkg;

	// Input opcodes carried in s_tuser
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_SHOW  = 2'd1,
		OP_TICK  = 2'd2
	} op_t;

	// Command kinds after classification by the front end
	typedef enum logic [2:0] {
		K_FILL,
		K_SKIP,
		K_SHOW,
		K_TICK,
		K_NOP
	} kind_t;

	// One classified command in the queue
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  first;
		logic [7:0]  fill_end;
		logic [23:0] word;
	} cmd_t;

	// Configuration as seen by front and back
	typedef struct packed {
		logic [7:0] used;
		logic [9:0] period;
		logic [9:0] one_high;
		logic [9:0] zero_high;
	} cfg_t;

	// Back end sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FILL,
		ST_SHOW1,
		ST_SHOW2
	} bstate_t;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_LED_COUNT = 2'd0;
	localparam logic [1:0] REG_PERIOD    = 2'd1;
	localparam logic [1:0] REG_ONE_HIGH  = 2'd2;
	localparam logic [1:0] REG_ZERO_HIGH = 2'd3;

	// Register reset values
	localparam logic [7:0] RST_LED_COUNT = 8'd64;
	localparam logic [9:0] RST_PERIOD    = 10'd50;
	localparam logic [9:0] RST_ONE_HIGH  = 10'd32;
	localparam logic [9:0] RST_ZERO_HIGH = 10'd16;

	// Most significant bit of a colour word, sent first
	localparam logic [4:0] BIT_TOP = 5'd23;

endpackage
`default_nettype wire

FILE: hdl/aldd_queue.sv
// Two-entry command queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module aldd_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  wire aldd_pkg::cmd_t in_cmd,
	output logic             out_valid,
	input  wire              out_pop,
	output aldd_pkg::cmd_t   out_cmd
);

	aldd_pkg::cmd_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	logic           pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_cmd   = entry_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_pop && out_valid;

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_cmd;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hdl/aldd_front.sv
// Front end: accepts input items and classifies them into commands.
`timescale 1ns / 1ps
`default_nettype none
module aldd_front (
	input  wire              s_tvalid,
	output logic             s_tready,
	input  wire  [39:0]      s_tdata,
	input  wire  [1:0]       s_tuser,
	input  wire  [7:0]       used,
	output logic             cmd_valid,
	input  wire              cmd_ready,
	output aldd_pkg::cmd_t   cmd
);

	logic [7:0] first;
	logic [7:0] run;
	logic [8:0] run_end;

	assign first   = s_tdata[7:0];
	assign run     = s_tdata[15:8];
	assign run_end = {1'b0, first} + {1'b0, run};

	assign s_tready  = cmd_ready;
	assign cmd_valid = s_tvalid;

	// Classify the item and clamp the fill range to the used count
	always_comb begin
		cmd.kind     = aldd_pkg::K_NOP;
		cmd.first    = first;
		cmd.fill_end = used;
		cmd.word     = {s_tdata[31:24], s_tdata[23:16], s_tdata[39:32]};
		unique case (aldd_pkg::op_t'(s_tuser))
			aldd_pkg::OP_WRITE: begin
				if (first < used) begin
					cmd.kind = aldd_pkg::K_FILL;
					if (run != 8'd0 && run_end < {1'b0, used}) begin
						cmd.fill_end = run_end[7:0];
					end
				end else begin
					cmd.kind = aldd_pkg::K_SKIP;
				end
			end
			aldd_pkg::OP_SHOW: begin
				cmd.kind = (used == 8'd0) ? aldd_pkg::K_SKIP : aldd_pkg::K_SHOW;
			end
			aldd_pkg::OP_TICK: begin
				cmd.kind = aldd_pkg::K_TICK;
			end
			default: begin
				cmd.kind = aldd_pkg::K_NOP;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: hdl/aldd_back.sv
// Back end: colour memory, range fill, serial waveform and result register.
`timescale 1ns / 1ps
`default_nettype none
module aldd_back #(
	parameter int MAX_LEDS = 64
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire aldd_pkg::cfg_t cfg,
	input  wire              cmd_valid,
	input  wire aldd_pkg::cmd_t cmd,
	output logic             cmd_pop,
	output logic             m_tvalid,
	input  wire              m_tready,
	output logic [7:0]       m_tdata,
	output logic             m_tlast,
	output logic             m_tuser
);

	localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
	localparam logic [8:0] MAX_N = 9'(MAX_LEDS);

	aldd_pkg::bstate_t st_q, st_d;

	logic        busy_q, busy_d;
	logic [7:0]  led_q, led_d;
	logic [4:0]  bit_q, bit_d;
	logic [9:0]  tick_q, tick_d;
	logic [23:0] cur_q, cur_d;
	logic [23:0] nxt_q, nxt_d;
	logic        pf_q, pf_d;
	logic [7:0]  fidx_q, fidx_d;
	logic [7:0]  fend_q, fend_d;
	logic [23:0] fword_q, fword_d;

	logic [23:0]         store_q [MAX_LEDS];
	logic [MAX_LEDS-1:0] valid_q;
	logic [23:0]         rd_data_q;
	logic                rd_ok_q;
	logic                rd_en;
	logic [8:0]          rd_addr;
	logic [IDX_W-1:0]    rd_idx;
	logic [IDX_W-1:0]    wr_idx;
	logic                wr_en;
	logic [23:0]         fetched;

	logic        out_valid_q;
	logic        out_line_q;
	logic        out_sending_q;
	logic        out_done_q;
	logic        out_refused_q;
	logic        out_free;
	logic        load_out;
	logic        res_done;
	logic        res_refused;
	logic        res_line;
	logic [9:0]  high_ticks;

	logic [10:0] tick_inc;
	logic        wrap;
	logic [8:0]  led_inc;
	logic        last_led;

	assign out_free = !out_valid_q || m_tready;
	assign rd_idx   = rd_addr[IDX_W-1:0];
	assign wr_idx   = fidx_q[IDX_W-1:0];
	assign fetched  = rd_ok_q ? rd_data_q : 24'd0;

	assign tick_inc = {1'b0, tick_q} + 11'd1;
	assign wrap     = tick_inc >= {1'b0, cfg.period};
	assign led_inc  = {1'b0, led_q} + 9'd1;
	assign last_led = led_inc >= {1'b0, cfg.used};

	// Next state of the sequencer
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			aldd_pkg::ST_IDLE: begin
				if (cmd_valid && !busy_q) begin
					if (cmd.kind == aldd_pkg::K_FILL) begin
						st_d = aldd_pkg::ST_FILL;
					end else if (cmd.kind == aldd_pkg::K_SHOW) begin
						st_d = aldd_pkg::ST_SHOW1;
					end
				end
			end
			aldd_pkg::ST_FILL: begin
				if (fidx_q == fend_q && out_free) begin
					st_d = aldd_pkg::ST_IDLE;
				end
			end
			aldd_pkg::ST_SHOW1: begin
				st_d = aldd_pkg::ST_SHOW2;
			end
			aldd_pkg::ST_SHOW2: begin
				if (out_free) begin
					st_d = aldd_pkg::ST_IDLE;
				end
			end
			default: begin
				st_d = aldd_pkg::ST_IDLE;
			end
		endcase
	end

	// Datapath updates and result generation
	always_comb begin
		busy_d      = busy_q;
		led_d       = led_q;
		bit_d       = bit_q;
		tick_d      = tick_q;
		cur_d       = cur_q;
		nxt_d       = pf_q ? fetched : nxt_q;
		pf_d        = 1'b0;
		fidx_d      = fidx_q;
		fend_d      = fend_q;
		fword_d     = fword_q;
		cmd_pop     = 1'b0;
		load_out    = 1'b0;
		res_done    = 1'b0;
		res_refused = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = 9'd0;
		wr_en       = 1'b0;
		unique case (st_q)
			aldd_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					case (cmd.kind)
						aldd_pkg::K_FILL: begin
							if (busy_q) begin
								if (out_free) begin
									cmd_pop     = 1'b1;
									load_out    = 1'b1;
									res_refused = 1'b1;
								end
							end else begin
								cmd_pop = 1'b1;
								fidx_d  = cmd.first;
								fend_d  = cmd.fill_end;
								fword_d = cmd.word;
							end
						end
						aldd_pkg::K_SHOW: begin
							if (busy_q) begin
								if (out_free) begin
									cmd_pop     = 1'b1;
									load_out    = 1'b1;
									res_refused = 1'b1;
								end
							end else begin
								cmd_pop = 1'b1;
								rd_en   = 1'b1;
								rd_addr = 9'd0;
							end
						end
						aldd_pkg::K_SKIP: begin
							if (out_free) begin
								cmd_pop     = 1'b1;
								load_out    = 1'b1;
								res_refused = busy_q;
							end
						end
						aldd_pkg::K_TICK: begin
							if (out_free) begin
								cmd_pop  = 1'b1;
								load_out = 1'b1;
								if (busy_q) begin
									if (wrap) begin
										tick_d = 10'd0;
										if (bit_q == 5'd0) begin
											bit_d = aldd_pkg::BIT_TOP;
											if (last_led) begin
												busy_d   = 1'b0;
												led_d    = 8'd0;
												res_done = 1'b1;
											end else begin
												// Move to the next LED, prefetch the one after
												led_d   = led_inc[7:0];
												cur_d   = nxt_q;
												rd_en   = 1'b1;
												rd_addr = {1'b0, led_q} + 9'd2;
												pf_d    = 1'b1;
											end
										end else begin
											bit_d = bit_q - 5'd1;
										end
									end else begin
										tick_d = tick_inc[9:0];
									end
								end
							end
						end
						default: begin
							if (out_free) begin
								cmd_pop  = 1'b1;
								load_out = 1'b1;
							end
						end
					endcase
				end
			end
			aldd_pkg::ST_FILL: begin
				if (fidx_q != fend_q) begin
					wr_en  = 1'b1;
					fidx_d = fidx_q + 8'd1;
				end else if (out_free) begin
					load_out = 1'b1;
				end
			end
			aldd_pkg::ST_SHOW1: begin
				// LED 0 is back; fetch LED 1
				cur_d   = fetched;
				rd_en   = 1'b1;
				rd_addr = 9'd1;
			end
			aldd_pkg::ST_SHOW2: begin
				if (out_free) begin
					nxt_d    = fetched;
					busy_d   = 1'b1;
					led_d    = 8'd0;
					bit_d    = aldd_pkg::BIT_TOP;
					tick_d   = 10'd0;
					load_out = 1'b1;
				end
			end
			default: begin
				load_out = 1'b0;
			end
		endcase
	end

	// Line level after this item
	assign high_ticks = cur_d[bit_d] ? cfg.one_high : cfg.zero_high;
	assign res_line   = busy_d && (tick_d < high_ticks);

	// Colour memory with registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_idx] <= fword_q;
		end
		if (rd_en) begin
			rd_data_q <= store_q[rd_idx];
		end
	end

	// Entry valid bits: an entry never written reads as dark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_ok_q <= (rd_addr < MAX_N) && valid_q[rd_idx];
			end
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= aldd_pkg::ST_IDLE;
			busy_q      <= 1'b0;
			led_q       <= 8'd0;
			bit_q       <= aldd_pkg::BIT_TOP;
			tick_q      <= 10'd0;
			pf_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			busy_q <= busy_d;
			led_q  <= led_d;
			bit_q  <= bit_d;
			tick_q <= tick_d;
			pf_q   <= pf_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		cur_q   <= cur_d;
		nxt_q   <= nxt_d;
		fidx_q  <= fidx_d;
		fend_q  <= fend_d;
		fword_q <= fword_d;
		if (load_out) begin
			out_line_q    <= res_line;
			out_sending_q <= busy_d;
			out_done_q    <= res_done;
			out_refused_q <= res_refused;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_sending_q, out_line_q};
	assign m_tlast  = out_done_q;
	assign m_tuser  = out_refused_q;

	// The frame ends only together with a frame-done result
	a_end_reports_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> out_valid_q && out_done_q)
		else $error("frame ended without a frame-done result");

	// A frame starts only with a sending, unrefused result
	a_start_reports_sending: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> out_valid_q && out_sending_q && !out_refused_q)
		else $error("frame started without a matching result");

	// No colour fill runs during a frame
	a_fill_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == aldd_pkg::ST_FILL) |-> !busy_q)
		else $error("colour fill while sending");

	// A prefetch is only pending inside a frame
	a_prefetch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pf_q |-> busy_q && (st_q == aldd_pkg::ST_IDLE))
		else $error("prefetch outside a frame");

endmodule
`default_nettype wire

FILE: hdl/addressable_led_frame_driver.sv
// Top level of the addressable LED frame driver: register file and stream channels.
`timescale 1ns / 1ps
`default_nettype none
// Drives a chain of up to MAX_LEDS addressable LEDs from a store of 24-bit colours
// (green, red, blue, sent MSB first), dark after reset. Each input item is a range
// write, a show command or one clock tick of the serial waveform, and gives exactly one
// result item. Ticks, refused commands and no-op items are done in the idle state, so a
// steady tick stream runs at one item per cycle while results are taken. A show first
// reads LEDs 0 and 1 and a range write first stores its clamped range: the colour
// memory has one write port and a registered read port, and the fill writes one entry
// per cycle. A two-entry command queue sits between the classifying front end and the
// executing back end, and an output register lets input be taken while a result waits.
// Configuration registers: led_count at 0x0, bit_period_ticks at 0x4, one_high_ticks at
// 0x8, zero_high_ticks at 0xC; write them only while no item is in flight.
module addressable_led_frame_driver #(
	parameter int MAX_LEDS = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	// Configuration port
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input items
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [39:0] s_tdata,  // first_led, run_length, red, green, blue
	input  wire  [1:0]  s_tuser,  // opcode
	// Result items
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [7:0]  m_tdata,  // line_level, sending, zero fill
	output logic        m_tlast,
	output logic        m_tuser   // refused
);

	localparam logic [7:0] MAX_N = 8'(MAX_LEDS);

	logic [7:0]     led_count_q;
	logic [9:0]     period_q;
	logic [9:0]     one_high_q;
	logic [9:0]     zero_high_q;
	logic           cfg_write;
	aldd_pkg::cfg_t cfg;

	logic           fr_valid;
	logic           fr_ready;
	aldd_pkg::cmd_t fr_cmd;
	logic           q_valid;
	logic           q_pop;
	aldd_pkg::cmd_t q_cmd;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q <= aldd_pkg::RST_LED_COUNT;
			period_q    <= aldd_pkg::RST_PERIOD;
			one_high_q  <= aldd_pkg::RST_ONE_HIGH;
			zero_high_q <= aldd_pkg::RST_ZERO_HIGH;
		end else if (cfg_write) begin
			unique case (paddr[3:2])
				aldd_pkg::REG_LED_COUNT: led_count_q <= pwdata[7:0];
				aldd_pkg::REG_PERIOD:    period_q    <= pwdata[9:0];
				aldd_pkg::REG_ONE_HIGH:  one_high_q  <= pwdata[9:0];
				aldd_pkg::REG_ZERO_HIGH: zero_high_q <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		unique case (paddr[3:2])
			aldd_pkg::REG_LED_COUNT: prdata = {24'd0, led_count_q};
			aldd_pkg::REG_PERIOD:    prdata = {22'd0, period_q};
			aldd_pkg::REG_ONE_HIGH:  prdata = {22'd0, one_high_q};
			aldd_pkg::REG_ZERO_HIGH: prdata = {22'd0, zero_high_q};
			default:                 prdata = 32'd0;
		endcase
	end

	// Clamp the LED count to the store size
	assign cfg.used      = (led_count_q < MAX_N) ? led_count_q : MAX_N;
	assign cfg.period    = period_q;
	assign cfg.one_high  = one_high_q;
	assign cfg.zero_high = zero_high_q;

	aldd_front u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.used      (cfg.used),
		.cmd_valid (fr_valid),
		.cmd_ready (fr_ready),
		.cmd       (fr_cmd)
	);

	aldd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_cmd    (fr_cmd),
		.out_valid (q_valid),
		.out_pop   (q_pop),
		.out_cmd   (q_cmd)
	);

	aldd_back #(
		.MAX_LEDS (MAX_LEDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (q_valid),
		.cmd       (q_cmd),
		.cmd_pop   (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Testbench for the addressable LED frame driver: stream stimulus, chain predictor, result checks.
`timescale 1ns / 1ps
module tb;

	localparam int LED_SLOTS = 64;
	localparam int MAX_GAP = 18;
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT = 2000;
	localparam int LONG_HOLD = 300;
	localparam logic [1:0] OP_NONE = 2'd3;

	// Expected fields of one result item
	typedef struct packed {
		logic line_level;
		logic sending;
		logic frame_done;
		logic refused;
	} line_state_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;  // first_led, run_length, red, green, blue
	logic [1:0]  s_tuser;  // opcode
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;  // line_level, sending, zero fill
	logic        m_tlast;
	logic        m_tuser;  // refused

	// Predicted chain state and configuration
	logic [23:0] led_colour [LED_SLOTS];
	logic        frame_busy;
	logic [7:0]  led_idx;
	logic [4:0]  bit_idx;
	logic [9:0]  tick_cnt;
	logic [7:0]  cfg_count;
	logic [9:0]  cfg_period;
	logic [9:0]  cfg_one;
	logic [9:0]  cfg_zero;

	line_state_t pending_line_states [$];
	int          mismatch_count = 0;
	bit          src_idle = 1'b1;
	bit          sink_idle = 1'b1;
	int          sink_hold = 0;

	addressable_led_frame_driver #(
		.MAX_LEDS(LED_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// LEDs actually driven: the register clamped to the store size
	function automatic logic [7:0] led_span();
		return (cfg_count < LED_SLOTS) ? cfg_count : 8'(LED_SLOTS);
	endfunction

	// Apply one item to the predicted chain and return the result it gives
	function automatic line_state_t advance_chain(input logic [1:0] op,
			input logic [7:0] first, input logic [7:0] run,
			input logic [7:0] red, input logic [7:0] green, input logic [7:0] blue);
		line_state_t res;
		logic [7:0]  used;
		logic [23:0] px;
		logic [9:0]  hi;
		logic [10:0] t;
		int          stop;
		int          k;
		res = '0;
		used = led_span();
		case (op)
			aldd_pkg::OP_WRITE: begin
				if (frame_busy) begin
					res.refused = 1'b1;
				end else if (first < used) begin
					stop = (run == 8'd0) ? int'(used) : int'(first) + int'(run);
					if (stop > int'(used))
						stop = int'(used);
					for (k = int'(first); k < stop; k++)
						led_colour[k] = {green, red, blue};
				end
			end
			aldd_pkg::OP_SHOW: begin
				if (frame_busy) begin
					res.refused = 1'b1;
				end else if (used > 8'd0) begin
					frame_busy = 1'b1;
					led_idx = 8'd0;
					bit_idx = aldd_pkg::BIT_TOP;
					tick_cnt = 10'd0;
				end
			end
			aldd_pkg::OP_TICK: begin
				if (frame_busy) begin
					t = {1'b0, tick_cnt} + 11'd1;
					if (t >= {1'b0, cfg_period}) begin
						tick_cnt = 10'd0;
						if (bit_idx == 5'd0) begin
							bit_idx = aldd_pkg::BIT_TOP;
							led_idx = led_idx + 8'd1;
							if (led_idx >= used) begin
								frame_busy = 1'b0;
								led_idx = 8'd0;
								res.frame_done = 1'b1;
							end
						end else begin
							bit_idx = bit_idx - 5'd1;
						end
					end else begin
						tick_cnt = t[9:0];
					end
				end
			end
			default: ;
		endcase
		// line is high while the tick count is under the current bit's high time
		if (frame_busy) begin
			px = (led_idx < LED_SLOTS) ? led_colour[led_idx] : 24'd0;
			hi = px[bit_idx] ? cfg_one : cfg_zero;
			res.line_level = (tick_cnt < hi);
		end
		res.sending = frame_busy;
		return res;
	endfunction

	// Offer one item after a random gap and record its expected result on acceptance
	task automatic send_item(input logic [1:0] op, input logic [7:0] first,
			input logic [7:0] run, input logic [7:0] red, input logic [7:0] green,
			input logic [7:0] blue);
		int gap;
		gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {blue, green, red, run, first};
		do @(posedge clk); while (!(s_tvalid && s_tready));
		pending_line_states.push_back(advance_chain(op, first, run, red, green, blue));
	endtask

	// Send one item with random fields, mostly aimed inside the chain
	task automatic send_op(input logic [1:0] op);
		logic [7:0] first;
		logic [7:0] run;
		first = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, led_span()));
		run = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 4));
		send_item(op, first, run, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// Tick until the predicted frame is over
	task automatic finish_frame();
		while (frame_busy)
			send_op(aldd_pkg::OP_TICK);
	endtask

	// Stop offering and wait for every expected result, then let the pipeline settle
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_line_states.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write: setup cycle, then access until pready
	task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			aldd_pkg::REG_LED_COUNT: cfg_count = value[7:0];
			aldd_pkg::REG_PERIOD:    cfg_period = value[9:0];
			aldd_pkg::REG_ONE_HIGH:  cfg_one = value[9:0];
			aldd_pkg::REG_ZERO_HIGH: cfg_zero = value[9:0];
			default: ;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Drain, then write all four registers
	task automatic apply_config(input logic [7:0] count, input logic [9:0] period,
			input logic [9:0] one, input logic [9:0] zero);
		wait_drained();
		reg_write(aldd_pkg::REG_LED_COUNT, {24'd0, count});
		reg_write(aldd_pkg::REG_PERIOD, {22'd0, period});
		reg_write(aldd_pkg::REG_ONE_HIGH, {22'd0, one});
		reg_write(aldd_pkg::REG_ZERO_HIGH, {22'd0, zero});
	endtask

	// Every opcode, field extremes and refusals under reset settings
	task automatic test_commands();
		send_item(aldd_pkg::OP_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_item(OP_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_item(aldd_pkg::OP_WRITE, 8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF);
		send_item(aldd_pkg::OP_WRITE, 8'd63, 8'd255, 8'h00, 8'h00, 8'h00);
		send_item(aldd_pkg::OP_WRITE, 8'd64, 8'd1, 8'h12, 8'h34, 8'h56);
		send_item(aldd_pkg::OP_WRITE, 8'd255, 8'd0, 8'hAA, 8'hAA, 8'hAA);
		send_item(aldd_pkg::OP_WRITE, 8'd5, 8'd1, 8'hA5, 8'h5A, 8'h0F);
		send_item(aldd_pkg::OP_WRITE, 8'd1, 8'd2, 8'h80, 8'h01, 8'h7E);
		send_item(aldd_pkg::OP_SHOW, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00);
		send_item(aldd_pkg::OP_SHOW, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00);
		send_item(aldd_pkg::OP_WRITE, 8'd0, 8'd0, 8'h11, 8'h22, 8'h33);
		send_item(OP_NONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		repeat (5) send_op(aldd_pkg::OP_TICK);
	endtask

	// Register extremes, including changes that land in the middle of a frame
	task automatic test_config_corners();
		// shrink the chain mid-frame; high time covers the whole one-tick bit
		apply_config(8'd1, 10'd1, 10'd1, 10'd1);
		finish_frame();
		// a zero period ends a bit on every tick
		apply_config(8'd2, 10'd0, 10'd1022, 10'd1);
		send_op(aldd_pkg::OP_SHOW);
		finish_frame();
		// an empty chain never starts a frame and takes no writes
		apply_config(8'd0, 10'd2, 10'd1, 10'd1);
		send_op(aldd_pkg::OP_SHOW);
		send_op(aldd_pkg::OP_TICK);
		send_item(aldd_pkg::OP_WRITE, 8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF);
		// widest settings, then cut back so the frame ends soon
		apply_config(8'd255, 10'd1023, 10'd1022, 10'd1022);
		send_op(aldd_pkg::OP_SHOW);
		repeat (6) send_op(aldd_pkg::OP_TICK);
		apply_config(8'd1, 10'd2, 10'd1, 10'd1022);
		finish_frame();
	endtask

	// Hold the result side off while ticks keep coming, then pause the sender
	task automatic test_backpressure();
		apply_config(8'd1, 10'd2, 10'd2, 10'd1);
		src_idle = 1'b0;
		send_op(aldd_pkg::OP_SHOW);
		sink_hold = LONG_HOLD;
		repeat (40) send_op(aldd_pkg::OP_TICK);
		wait_drained();
		src_idle = 1'b1;
		finish_frame();
	endtask

	// Random phases: fills and shows while idle, mostly ticks while sending
	task automatic test_random_traffic();
		int phase;
		int k;
		int roll;
		int period;
		for (phase = 0; phase < 6; phase++) begin
			roll = $urandom_range(0, 9);
			period = $urandom_range(1, 3);
			apply_config((roll < 6) ? 8'd1 : (roll < 8) ? 8'd2 : 8'($urandom_range(3, 6)),
				10'(period), 10'($urandom_range(1, period + 1)),
				10'($urandom_range(1, period + 1)));
			for (k = 0; k < 250; k++) begin
				if ($urandom_range(0, 39) == 0)
					src_idle = !src_idle;
				if ($urandom_range(0, 39) == 0)
					sink_idle = !sink_idle;
				roll = $urandom_range(0, 99);
				if (frame_busy)
					send_op(roll < 88 ? aldd_pkg::OP_TICK : roll < 93 ? aldd_pkg::OP_WRITE
						: roll < 97 ? aldd_pkg::OP_SHOW : OP_NONE);
				else
					send_op(roll < 45 ? aldd_pkg::OP_WRITE : roll < 75 ? aldd_pkg::OP_SHOW
						: roll < 90 ? aldd_pkg::OP_TICK : OP_NONE);
			end
		end
		src_idle = 1'b1;
		sink_idle = 1'b1;
	endtask

	// Accept results with random stalls and compare each with the oldest expectation
	initial begin : result_check
		int          stall;
		line_state_t want;
		m_tready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
			if (sink_hold > 0) begin
				stall = sink_hold;
				sink_hold = 0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			if (pending_line_states.size() == 0) begin
				$error("unexpected result item: tdata %h tlast %b tuser %b",
					m_tdata, m_tlast, m_tuser);
				mismatch_count++;
			end else begin
				want = pending_line_states.pop_front();
				if (m_tdata[0] !== want.line_level) begin
					$error("line_level: expected %0b, got %0b", want.line_level, m_tdata[0]);
					mismatch_count++;
				end
				if (m_tdata[1] !== want.sending) begin
					$error("sending: expected %0b, got %0b", want.sending, m_tdata[1]);
					mismatch_count++;
				end
				if (m_tlast !== want.frame_done) begin
					$error("frame_done: expected %0b, got %0b", want.frame_done, m_tlast);
					mismatch_count++;
				end
				if (m_tuser !== want.refused) begin
					$error("refused: expected %0b, got %0b", want.refused, m_tuser);
					mismatch_count++;
				end
			end
		end
	end

	// End the run if no item moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("tb: FAIL");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int k;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= aldd_pkg::OP_TICK;
		// predictor starts from the reset state
		for (k = 0; k < LED_SLOTS; k++)
			led_colour[k] = 24'd0;
		frame_busy = 1'b0;
		led_idx = 8'd0;
		bit_idx = aldd_pkg::BIT_TOP;
		tick_cnt = 10'd0;
		cfg_count = aldd_pkg::RST_LED_COUNT;
		cfg_period = aldd_pkg::RST_PERIOD;
		cfg_one = aldd_pkg::RST_ONE_HIGH;
		cfg_zero = aldd_pkg::RST_ZERO_HIGH;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_commands();
		test_config_corners();
		test_backpressure();
		test_random_traffic();
		wait_drained();
		if (mismatch_count == 0 && pending_line_states.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

FILE: sim.f
hdl/aldd_pkg.sv
hdl/aldd_queue.sv
hdl/aldd_front.sv
hdl/aldd_back.sv
hdl/addressable_led_frame_driver.sv
tb/tb.sv
